>>> sv/superfasthash_name_hasher_defines.svh
// ---------------------------------------------------------------------------
// superfasthash_name_hasher_defines
// Assertion macros shared by the name hasher RTL.
// ---------------------------------------------------------------------------
`ifndef SUPERFASTHASH_NAME_HASHER_DEFINES_SVH
`define SUPERFASTHASH_NAME_HASHER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SHF_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shf assertion failed");

// next-cycle implication, disabled during reset
`define SHF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shf assertion failed");

`endif

>>> sv/shf_pkg.sv
// ---------------------------------------------------------------------------
// shf_pkg
// Shared constants and types for the name hasher.
// ---------------------------------------------------------------------------
package shf_pkg;

   // longest name that is hashed; later bytes are dropped
   localparam int MAX_NAME_LEN = 4096;
   localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);

   // front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // item kinds as classified by the front
   localparam logic [1:0] KIND_DATA  = 2'd0;  // name character
   localparam logic [1:0] KIND_TERM  = 2'd1;  // terminator, name not empty
   localparam logic [1:0] KIND_EMPTY = 2'd2;  // terminator of an empty name

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

endpackage

>>> sv/superfasthash_name_hasher.sv
// A terminator passes through the queue, then the registers v1, v2, v3, v4 and the result register,
// before rsp_valid rises; a stalled result port holds it in that pipeline.
// Throughput: one byte per cycle while the queue is not full; the queue absorbs a stalled result port.
// Each word is mixed as its bytes arrive (low half added on the second byte, mixing round on the fourth),
// the tail and avalanche by a five-stage add-shift-xor pipeline after the queue.
// Reset (synchronous): seed clears to 0, queue and pipeline empty, no name open.
// ---------------------------------------------------------------------------
// superfasthash_name_hasher
// 32-bit SuperFastHash over a zero-terminated name, one byte per item.
// ---------------------------------------------------------------------------
`include "superfasthash_name_hasher_defines.svh"

module superfasthash_name_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_name_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   logic                        q_full;
   logic                        push;
   shf_pkg::q_entry_type        push_entry;
   logic                        pop;
   shf_pkg::q_head_type         head;
   logic [shf_pkg::QCNT_W-1:0]  q_count;

   // front: accept and classify
   shf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_name_byte (req_name_byte),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // decoupling queue
   shf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .count      (q_count)
   );

   // back: hashing and result
   shf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   // queue never written when full, never read when empty
   `SHF_ASSERT(a_no_overflow, clock, reset, push, q_count != shf_pkg::QCNT_W'(shf_pkg::QUEUE_DEPTH))
   `SHF_ASSERT(a_no_underflow, clock, reset, pop, q_count != '0)
   // a terminator is never dropped by the front
   `SHF_ASSERT_NEXT(a_term_queued, clock, reset, req_valid && req_ready && (req_name_byte == 8'd0), q_count != '0)

endmodule

>>> sv/shf_front.sv
// ---------------------------------------------------------------------------
// shf_front
// Accepts name bytes, applies the length cap and tags each item.
// ---------------------------------------------------------------------------
module shf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_name_byte,
   input  logic                 q_full,
   output logic                 push,
   output shf_pkg::q_entry_type push_entry
);

   localparam logic [shf_pkg::LEN_W-1:0] LEN_CAP = shf_pkg::LEN_W'(shf_pkg::MAX_NAME_LEN);

   logic [shf_pkg::LEN_W-1:0] len_ff;
   logic [shf_pkg::LEN_W-1:0] len_in;
   logic                      accept;
   logic                      is_term;
   logic                      under_cap;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_term   = (req_name_byte == 8'd0);
   assign under_cap = (len_ff < LEN_CAP);

   // classify: terminators always go through, characters only below the cap
   always_comb begin
      push            = accept && (is_term || under_cap);
      push_entry.data = req_name_byte;
      if (!is_term) begin
         push_entry.kind = shf_pkg::KIND_DATA;
      end else if (len_ff == '0) begin
         push_entry.kind = shf_pkg::KIND_EMPTY;
      end else begin
         push_entry.kind = shf_pkg::KIND_TERM;
      end
   end

   // accepted length of the current name
   always_comb begin
      len_in = len_ff;
      if (accept) begin
         if (is_term) begin
            len_in = '0;
         end else if (under_cap) begin
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

>>> sv/shf_queue.sv
// ---------------------------------------------------------------------------
// shf_queue
// Short FIFO that decouples the front from the hashing back end.
// ---------------------------------------------------------------------------
module shf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  shf_pkg::q_entry_type        push_entry,
   input  logic                        pop,
   output shf_pkg::q_head_type         head,
   output logic                        full,
   output logic [shf_pkg::QCNT_W-1:0]  count
);

   localparam logic [shf_pkg::QCNT_W-1:0] DEPTH = shf_pkg::QCNT_W'(shf_pkg::QUEUE_DEPTH);

   shf_pkg::q_entry_type             mem_ff [shf_pkg::QUEUE_DEPTH];
   logic [shf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [shf_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [shf_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == DEPTH);
   assign count      = count_ff;
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> sv/shf_back.sv
// ---------------------------------------------------------------------------
// shf_back
// Word mixing, tail fold, avalanche pipeline and result register.
// ---------------------------------------------------------------------------
module shf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  shf_pkg::q_head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_hash_value
);

   // seed register
   logic [31:0] seed_ff;

   // accumulator
   logic        started_ff, started_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] pend_ff, pend_in;
   logic [31:0] hash_ff, hash_in;

   // finalize pipeline
   logic        v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic [31:0] s1_x_ff, s2_x_ff, s3_x_ff, s4_x_ff, rsp_hash_ff;
   logic [1:0]  s1_cnt_ff;
   logic [7:0]  s1_b2_ff;
   logic        s1_empty_ff, s2_empty_ff, s3_empty_ff, s4_empty_ff;

   logic        adv;
   logic        is_data;
   logic        pop_data;
   logic        pop_term;
   logic [7:0]  b;
   logic [31:0] h_cur;
   logic [15:0] hi16;
   logic [31:0] mix_t, mix_x, mix_h;
   logic [31:0] s1_x_in;
   logic [31:0] t2_a, s2_x_in;
   logic [31:0] t3_a, s3_x_in;
   logic [31:0] t4_a, s4_x_in;
   logic [31:0] t5_a, t5_h;

   // pop control: a terminator only leaves when the pipeline can move
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign is_data  = (head.entry.kind == shf_pkg::KIND_DATA);
   assign pop      = head.valid && (is_data || adv);
   assign pop_data = pop && is_data;
   assign pop_term = pop && !is_data;
   assign b        = head.entry.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // one mixing round on a full word (low half already added)
   always_comb begin
      h_cur = started_ff ? hash_ff : seed_ff;
      hi16  = {b, pend_ff[23:16]};
      mix_t = {5'b0, hi16, 11'b0} ^ hash_ff;
      mix_x = {hash_ff[15:0], 16'b0} ^ mix_t;
      mix_h = mix_x + {11'b0, mix_x[31:11]};
   end

   // accumulator next state; the low half is added on the second byte
   always_comb begin
      started_in = started_ff;
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      hash_in    = hash_ff;
      if (pop_data) begin
         started_in = 1'b1;
         phase_in   = phase_ff + 1'b1;
         unique case (phase_ff)
            2'd0: begin
               pend_in = {16'b0, b};
               hash_in = h_cur;
            end
            2'd1: begin
               pend_in = {8'b0, b, pend_ff[7:0]};
               hash_in = h_cur + {16'b0, b, pend_ff[7:0]};
            end
            2'd2: begin
               pend_in = {b, pend_ff[15:0]};
            end
            2'd3: begin
               pend_in = '0;
               hash_in = mix_h;
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end else if (pop_term) begin
         started_in = 1'b0;
         phase_in   = '0;
         pend_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         phase_ff   <= '0;
         pend_ff    <= '0;
         hash_ff    <= '0;
      end else begin
         started_ff <= started_in;
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         hash_ff    <= hash_in;
      end
   end

   // stage 1: a single held byte is added here
   assign s1_x_in = hash_ff + ((phase_ff == 2'd1) ? {24'b0, pend_ff[7:0]} : 32'd0);

   // stage 2: tail shuffle by held byte count
   always_comb begin
      t2_a    = s1_x_ff;
      s2_x_in = s1_x_ff;
      case (s1_cnt_ff)
         2'd1: begin
            t2_a    = s1_x_ff ^ {s1_x_ff[21:0], 10'b0};
            s2_x_in = t2_a + {1'b0, t2_a[31:1]};
         end
         2'd2: begin
            t2_a    = s1_x_ff ^ {s1_x_ff[20:0], 11'b0};
            s2_x_in = t2_a + {17'b0, t2_a[31:17]};
         end
         2'd3: begin
            t2_a    = s1_x_ff ^ {s1_x_ff[15:0], 16'b0} ^ {6'b0, s1_b2_ff, 18'b0};
            s2_x_in = t2_a + {11'b0, t2_a[31:11]};
         end
         default: begin
            s2_x_in = s1_x_ff;
         end
      endcase
   end

   // stages 3 to 5: avalanche
   always_comb begin
      t3_a    = s2_x_ff ^ {s2_x_ff[28:0], 3'b0};
      s3_x_in = t3_a + {5'b0, t3_a[31:5]};
      t4_a    = s3_x_ff ^ {s3_x_ff[27:0], 4'b0};
      s4_x_in = t4_a + {17'b0, t4_a[31:17]};
      t5_a    = s4_x_ff ^ {s4_x_ff[6:0], 25'b0};
      t5_h    = t5_a + {6'b0, t5_a[31:6]};
   end

   // pipeline valids, held as a whole while the result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop_term;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff     <= s1_x_in;
         s1_cnt_ff   <= phase_ff;
         s1_b2_ff    <= pend_ff[23:16];
         s1_empty_ff <= (head.entry.kind == shf_pkg::KIND_EMPTY);
         s2_x_ff     <= s2_x_in;
         s2_empty_ff <= s1_empty_ff;
         s3_x_ff     <= s3_x_in;
         s3_empty_ff <= s2_empty_ff;
         s4_x_ff     <= s4_x_in;
         s4_empty_ff <= s3_empty_ff;
         rsp_hash_ff <= s4_empty_ff ? 32'd0 : t5_h;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule
